[rtl/wvm_pkg.sv]
// ----------------------------------------------------------------------------
// Wavetable voice mixer package
// Shared widths, command and register codes, the control state type and the
// voice table entry layout.
// ----------------------------------------------------------------------------
package wvm_pkg;

  // Field widths of the item, result and configuration channels
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned INDEX_W    = 9;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MIX_W      = 21;
  localparam int unsigned ACTIVE_W   = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Fixed-point details
  localparam int unsigned PHASE_INT_W = 16;  // integer part of a 16.16 phase
  localparam int unsigned FRAC_W      = 8;   // interpolation fraction bits
  localparam int unsigned GAIN_SHIFT  = 15;  // Q15 gain
  localparam int unsigned ACC_W       = 22;  // mix accumulator, one guard bit

  localparam logic [PHASE_W-1:0] PHASE_ONE = 32'h0001_0000;

  // Item commands (code 3 is unused)
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_SAMPLE = 2'd0,
    CMD_WRITE_VOICE  = 2'd1,
    CMD_TICK         = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VOICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE   = 2'd1;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWRITE,
    ST_MIX,
    ST_DONE
  } state_e;

  // One voice table entry
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] step;
    logic [GAIN_W-1:0]  gain;
  } voice_t;

endpackage

[rtl/wvm_intf.sv]
// ----------------------------------------------------------------------------
// Wavetable voice mixer channels
// Valid/ready channels for command items, mixed frames and register writes.
// ----------------------------------------------------------------------------
interface wvm_item_if import wvm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [INDEX_W-1:0]        index;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [PHASE_W-1:0]        start_phase;
  logic [PHASE_W-1:0]        phase_step;
  logic signed [GAIN_W-1:0]  voice_gain;

  modport source (output valid, command, index, sample_value, start_phase, phase_step,
                  voice_gain, input ready);
  modport sink   (input valid, command, index, sample_value, start_phase, phase_step,
                  voice_gain, output ready);
endinterface

interface wvm_mix_if import wvm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MIX_W-1:0] mix_sample;

  modport source (output valid, mix_sample, input ready);
  modport sink   (input valid, mix_sample, output ready);
endinterface

interface wvm_cfg_if import wvm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/wvm_mod_unit.sv]
// ----------------------------------------------------------------------------
// Wavetable voice mixer address reduction
// Two-stage pipeline giving x modulo DEPTH for a 16-bit x: a reciprocal
// multiply yields the exact quotient, then quotient times DEPTH is removed.
// ----------------------------------------------------------------------------
module wvm_mod_unit import wvm_pkg::*; #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [PHASE_INT_W-1:0]   x_i,
  output logic                     valid_o,
  output logic [$clog2(DEPTH)-1:0] rem_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned XW   = PHASE_INT_W;
  localparam int unsigned SH   = XW + AW;
  localparam int unsigned MW   = XW + 2;
  localparam int unsigned PW   = XW + MW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + DEPTH - 1) / DEPTH;
  localparam logic [MW-1:0]   RECIP_V = MW'(RECIP);
  localparam logic [31:0]     DEPTH_V = 32'(DEPTH);

  logic          v1_q, v2_q;
  logic [XW-1:0] x1_q, quo1_q;
  logic [AW-1:0] rem2_q;
  logic [PW-1:0] qprod;
  logic [31:0]   back;

  // Quotient: floor(x * ceil(2^SH / DEPTH) / 2^SH) is exact for any 16-bit x
  assign qprod = PW'(x_i) * PW'(RECIP_V);
  // Quotient times depth, subtracted in the second stage
  assign back  = 32'(quo1_q) * DEPTH_V;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x_i;
    quo1_q <= XW'(qprod >> SH);
    rem2_q <= AW'(32'(x1_q) - back);
  end

  assign valid_o = v2_q;
  assign rem_o   = rem2_q;

endmodule

[rtl/wavetable_voice_mixer_core.sv]
// ----------------------------------------------------------------------------
// Wavetable voice mixer core
// Timing: a voice write lands in the table at its transfer; a sample write
//   first passes the address reduction. A tick walks the n voices summed
//   through the table read, address reduction, store read and the mixing
//   registers, then loads its frame once the previous frame has left.
// Throughput: one item at a time; the next item waits until the frame is loaded.
// Reset: control and registers clear; sample store and voice table contents
//   hold no reset value and must be written before they are played.
// ----------------------------------------------------------------------------
module wavetable_voice_mixer_core import wvm_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = 512,
  parameter int unsigned VOICE_SLOTS  = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wvm_item_if.sink    item_if,
  wvm_mix_if.source   mix_if,
  wvm_cfg_if.sink     cfg_if
);

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned VW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam logic [6:0]         SLOTS_V   = 7'(VOICE_SLOTS);
  localparam logic [INDEX_W-1:0] SLOTS_IDX = INDEX_W'(VOICE_SLOTS);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(SAMPLE_DEPTH - 1);
  localparam logic signed [ACC_W-1:0] MIX_MAX_ACC = 22'sd1048575;
  localparam logic signed [ACC_W-1:0] MIX_MIN_ACC = -22'sd1048576;

  // Storage
  logic signed [SAMPLE_W-1:0] smem [SAMPLE_DEPTH];
  voice_t                     vmem [VOICE_SLOTS];

  // Control
  state_e                state_q, state_d;
  logic                  in_ready, issue, load_out, busy;
  logic                  accept, swr_start, vwr_start, tick_start;
  cmd_e                  cmd;
  logic [ACTIVE_W-1:0]   active_q, n_q, n_d, vcnt_q;
  logic                  interp_q;
  logic                  out_valid_q;
  logic signed [MIX_W-1:0] mix_q, mix_sat;
  logic signed [SAMPLE_W-1:0] wdata_q;

  // Pipeline
  logic                  v1_q, t2_v_q, v4_q, v5_q, v6_q, v7_q;
  logic [VW-1:0]         v1_addr_q;
  voice_t                vrd_q;
  logic [FRAC_W-1:0]     t2_frac_q, t3_frac_q, t4_frac_q;
  logic [GAIN_W-1:0]     t2_gain_q, t3_gain_q, t4_gain_q;
  logic                  mod_valid;
  logic [AW-1:0]         mod_rem, nxt_addr;
  logic                  mod_in_valid;
  logic [PHASE_INT_W-1:0] mod_x;
  logic signed [SAMPLE_W-1:0] a_q, b_q, a5_q, s6_q;
  logic signed [GAIN_W-1:0]   g5_q, g6_q;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [25:0]         ip_prod, p5_q, s_full;
  logic signed [31:0]         m_prod, m7_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [GAIN_SHIFT+1:0] term;
  logic [PHASE_W-1:0]         phase_inc;
  logic                       vmem_we;
  logic [VW-1:0]              vmem_waddr;
  voice_t                     vmem_wdata;

  // ---------------------------------------------------------------- handshakes
  assign cmd        = cmd_e'(item_if.command);
  assign accept     = item_if.valid && in_ready;
  assign swr_start  = accept && (cmd == CMD_WRITE_SAMPLE);
  assign tick_start = accept && (cmd == CMD_TICK);
  assign vwr_start  = accept && (cmd == CMD_WRITE_VOICE) && (item_if.index < SLOTS_IDX);

  assign item_if.ready = in_ready;
  assign cfg_if.ready  = 1'b1;
  assign mix_if.valid  = out_valid_q;
  assign mix_if.mix_sample = mix_q;

  // Voices summed this frame, capped at the table size
  assign n_d = ({2'b00, active_q} > SLOTS_V) ? SLOTS_V[ACTIVE_W-1:0] : active_q;

  assign busy = v1_q || t2_v_q || mod_valid || v4_q || v5_q || v6_q || v7_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (swr_start) begin
          state_d = ST_SWRITE;
        end else if (tick_start) begin
          state_d = ST_MIX;
        end
      end
      ST_SWRITE: begin
        if (mod_valid) begin
          state_d = ST_IDLE;
        end
      end
      ST_MIX: begin
        if (!issue && !busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_SWRITE: in_ready = 1'b0;
      ST_MIX:    issue    = (vcnt_q < n_q);
      ST_DONE:   load_out = !out_valid_q || mix_if.ready;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      interp_q    <= 1'b0;
      n_q         <= '0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      t2_v_q      <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      // register writes
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CFG_ACTIVE_VOICES: active_q <= cfg_if.data;
          CFG_INTERPOLATE:   interp_q <= cfg_if.data[0];
          default:           active_q <= active_q;
        endcase
      end
      // voice walk
      if (tick_start) begin
        n_q    <= n_d;
        vcnt_q <= '0;
      end else if (issue) begin
        vcnt_q <= vcnt_q + 1'b1;
      end
      // output register
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (mix_if.ready) begin
        out_valid_q <= 1'b0;
      end
      // pipeline valids
      v1_q   <= issue;
      t2_v_q <= v1_q;
      v4_q   <= mod_valid && (state_q == ST_MIX);
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
    end
  end

  // ---------------------------------------------------------------- voice table
  // One write port shared by voice writes (idle) and phase write-back (mixing);
  // each voice is read once per frame, so no read meets its own write-back.
  assign phase_inc  = interp_q ? vrd_q.step : PHASE_ONE;
  assign vmem_we    = vwr_start || v1_q;
  assign vmem_waddr = v1_q ? v1_addr_q : VW'(item_if.index);
  always_comb begin
    if (v1_q) begin
      vmem_wdata       = vrd_q;
      vmem_wdata.phase = vrd_q.phase + phase_inc;
    end else begin
      vmem_wdata.phase = item_if.start_phase;
      vmem_wdata.step  = item_if.phase_step;
      vmem_wdata.gain  = item_if.voice_gain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem[vmem_waddr] <= vmem_wdata;
    end
    vrd_q     <= vmem[VW'(vcnt_q)];
    v1_addr_q <= VW'(vcnt_q);
  end

  // ---------------------------------------------------------------- address reduction
  assign mod_in_valid = v1_q || swr_start;
  assign mod_x = v1_q ? vrd_q.phase[PHASE_W-1:PHASE_W-PHASE_INT_W]
                      : PHASE_INT_W'(item_if.index);

  wvm_mod_unit #(
    .DEPTH (SAMPLE_DEPTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mod_in_valid),
    .x_i     (mod_x),
    .valid_o (mod_valid),
    .rem_o   (mod_rem)
  );

  assign nxt_addr = (mod_rem == LAST_ADDR) ? '0 : mod_rem + 1'b1;

  // ---------------------------------------------------------------- sample store
  always_ff @(posedge clk_i) begin
    if (swr_start) begin
      wdata_q <= item_if.sample_value;
    end
    if ((state_q == ST_SWRITE) && mod_valid) begin
      smem[mod_rem] <= wdata_q;
    end
    a_q <= smem[mod_rem];
    b_q <= smem[nxt_addr];
  end

  // ---------------------------------------------------------------- mixing datapath
  // Fraction is forced to zero in plain mode, leaving the sample at the phase
  assign diff    = {b_q[SAMPLE_W-1], b_q} - {a_q[SAMPLE_W-1], a_q};
  assign ip_prod = diff * $signed({1'b0, t4_frac_q});
  assign s_full  = 26'(a5_q) + (p5_q >>> FRAC_W);
  assign m_prod  = s6_q * g6_q;
  assign term    = m7_q[31:GAIN_SHIFT];

  always_ff @(posedge clk_i) begin
    // tags travelling alongside the address reduction
    t2_frac_q <= interp_q ? vrd_q.phase[2*FRAC_W-1:FRAC_W] : '0;
    t2_gain_q <= vrd_q.gain;
    t3_frac_q <= t2_frac_q;
    t3_gain_q <= t2_gain_q;
    t4_frac_q <= t3_frac_q;
    t4_gain_q <= t3_gain_q;
    // interpolate, scale, accumulate
    p5_q <= ip_prod;
    a5_q <= a_q;
    g5_q <= $signed(t4_gain_q);
    s6_q <= s_full[SAMPLE_W-1:0];
    g6_q <= g5_q;
    m7_q <= m_prod;
    if (tick_start) begin
      acc_q <= '0;
    end else if (v7_q) begin
      acc_q <= acc_q + ACC_W'(term);
    end
    if (load_out) begin
      mix_q <= mix_sat;
    end
  end

  // Clamp to the frame range
  always_comb begin
    if (acc_q > MIX_MAX_ACC) begin
      mix_sat = MIX_MAX_ACC[MIX_W-1:0];
    end else if (acc_q < MIX_MIN_ACC) begin
      mix_sat = MIX_MIN_ACC[MIX_W-1:0];
    end else begin
      mix_sat = acc_q[MIX_W-1:0];
    end
  end

`ifndef SYNTHESIS
  // Nothing in flight once the sequencer is back to idle
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !(v1_q || t2_v_q || v4_q || v5_q || v6_q || v7_q))
    else $error("mixing pipeline busy while idle");

  // Voice walk stays within the frame's voice count
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> (vcnt_q <= n_q))
    else $error("voice counter overran");

  // A finished frame waits while the previous one is still unaccepted
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_q && !mix_if.ready) |=> (state_q == ST_DONE))
    else $error("frame dropped over a pending result");

  // Reduced addresses stay inside the store
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_valid |-> (32'(mod_rem) < 32'(SAMPLE_DEPTH)))
    else $error("sample address out of range");
`endif

endmodule

[test/wavetable_voice_mixer_core_tb.sv]
// ----------------------------------------------------------------------------
// Wavetable voice mixer core testbench
// Fills the sample store and voice table, then drives directed and random
// command items. The results are checked against a bit-true frame predictor
// held in a scoreboard. Both channels idle at random, and one long output
// stall is included to back up the command channel.
// ----------------------------------------------------------------------------
module wavetable_voice_mixer_core_tb;
  import wvm_pkg::*;

  localparam int unsigned DEPTH        = 512;
  localparam int unsigned VOICES       = 24;
  localparam int          CLK_PERIOD   = 20;
  localparam int          MIX_MAX      = 1048575;
  localparam int          MIX_MIN      = -1048576;
  localparam int          SETTLE_CYCLES = 40;      // covers the longest frame latency
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          NUM_PHASES   = 9;
  localparam int          PHASE_ITEMS  = 60;

  // Codes the package leaves unnamed
  localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: frame predictor and the queue of expected frames
  // --------------------------------------------------------------------------
  class voice_mix_scoreboard;
    int        store_word [DEPTH];
    bit [31:0] phase_of [VOICES];
    bit [31:0] step_of [VOICES];
    int        gain_of [VOICES];
    int        active;
    bit        interp;
    int        expected_frames [$];
    int        errors;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ACTIVE_VOICES) begin
        active = data;
      end else if (idx == CFG_INTERPOLATE) begin
        interp = data[0];
      end
    endfunction

    // One frame: sum of the gained voice samples, advancing each phase
    function int mix_frame();
      int        n;
      int        pos;
      int        nxt;
      int        a;
      int        b;
      int        s;
      int        sum;
      bit [31:0] ph;
      n   = (active > VOICES) ? VOICES : active;
      sum = 0;
      for (int v = 0; v < n; v++) begin
        ph  = phase_of[v];
        pos = ph[31:16] % DEPTH;
        a   = store_word[pos];
        if (!interp) begin
          s           = a;
          phase_of[v] = ph + PHASE_ONE;
        end else begin
          nxt         = (pos + 1) % DEPTH;
          b           = store_word[nxt];
          s           = a + (((b - a) * int'(ph[15:8])) >>> FRAC_W);
          phase_of[v] = ph + step_of[v];
        end
        sum += (s * gain_of[v]) >>> GAIN_SHIFT;
      end
      if (sum > MIX_MAX) sum = MIX_MAX;
      if (sum < MIX_MIN) sum = MIX_MIN;
      return sum;
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                            logic signed [SAMPLE_W-1:0] sval, logic [PHASE_W-1:0] ph,
                            logic [PHASE_W-1:0] st, logic signed [GAIN_W-1:0] g);
      case (cmd)
        CMD_WRITE_SAMPLE: begin
          store_word[idx % DEPTH] = sval;
        end
        CMD_WRITE_VOICE: begin
          if (idx < VOICES) begin
            phase_of[idx] = ph;
            step_of[idx]  = st;
            gain_of[idx]  = g;
          end
        end
        CMD_TICK: begin
          expected_frames.push_back(mix_frame());
        end
        default: ;
      endcase
    endfunction

    function void check_frame(logic signed [MIX_W-1:0] actual);
      logic signed [MIX_W-1:0] want;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none, actual %0d", $time, actual);
        return;
      end
      want = expected_frames.pop_front();
      if (actual !== want) begin
        errors++;
        $display("%0t: mix_sample mismatch, expected %0d, actual %0d", $time, want, actual);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   gaps_on  = 1'b1;
  bit   hold_req = 1'b0;
  int   cycle_count = 0;
  voice_mix_scoreboard sb;

  wvm_item_if item_bus ();
  wvm_mix_if  mix_bus ();
  wvm_cfg_if  cfg_bus ();

  wavetable_voice_mixer_core #(
    .SAMPLE_DEPTH (DEPTH),
    .VOICE_SLOTS  (VOICES)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_if (item_bus),
    .mix_if  (mix_bus),
    .cfg_if  (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Frame monitor
  always @(posedge clk_i) begin
    if (rst_ni && mix_bus.valid && mix_bus.ready) sb.check_frame(mix_bus.mix_sample);
  end

  // Frame receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        mix_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        mix_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        mix_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Register write; valid is left high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(int unsigned voices, bit mode);
    write_reg(CFG_ACTIVE_VOICES, CFG_DATA_W'(voices));
    write_reg(CFG_INTERPOLATE, {4'($urandom), mode});
    cfg_bus.valid <= 1'b0;
  endtask

  // One item transfer; valid stays high unless a gap follows
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                           logic [SAMPLE_W-1:0] sval, logic [PHASE_W-1:0] ph,
                           logic [PHASE_W-1:0] st, logic [GAIN_W-1:0] g);
    item_bus.valid        <= 1'b1;
    item_bus.command      <= cmd;
    item_bus.index        <= idx;
    item_bus.sample_value <= sval;
    item_bus.start_phase  <= ph;
    item_bus.phase_step   <= st;
    item_bus.voice_gain   <= g;
    do @(posedge clk_i); while (!item_bus.ready);
    sb.note_item(cmd, idx, sval, ph, st, g);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, INDEX_W'($urandom), SAMPLE_W'($urandom), $urandom, $urandom,
              GAIN_W'($urandom));
  endtask

  task automatic send_voice(logic [INDEX_W-1:0] idx, logic [PHASE_W-1:0] ph,
                            logic [PHASE_W-1:0] st, logic [GAIN_W-1:0] g);
    send_item(CMD_WRITE_VOICE, idx, SAMPLE_W'($urandom), ph, st, g);
  endtask

  task automatic send_sample(logic [INDEX_W-1:0] addr, logic [SAMPLE_W-1:0] value);
    send_item(CMD_WRITE_SAMPLE, addr, value, $urandom, $urandom, GAIN_W'($urandom));
  endtask

  // Wait for every frame, then let a trailing write finish
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_frames.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    int unsigned       pick;
    logic [SAMPLE_W-1:0] value;
    logic [PHASE_W-1:0]  st;
    logic [INDEX_W-1:0]  voice;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_tick();
    end else if (pick < 70) begin
      value = SAMPLE_W'($urandom);
      if ($urandom_range(0, 7) == 0) value = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      send_sample(INDEX_W'($urandom), value);
    end else if (pick < 94) begin
      // Mostly small steps; now and then any step
      st    = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0003_0000);
      voice = $urandom_range(0, 5) == 0 ? INDEX_W'($urandom)
                                        : INDEX_W'($urandom_range(0, VOICES - 1));
      send_voice(voice, $urandom, st, GAIN_W'($urandom));
    end else begin
      send_item(CMD_SPARE, INDEX_W'($urandom), SAMPLE_W'($urandom), $urandom, $urandom,
                GAIN_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned     phase_voices [NUM_PHASES];
    bit              phase_interp [NUM_PHASES];
    logic [SAMPLE_W-1:0] value;

    sb = new();
    item_bus.valid        <= 1'b0;
    item_bus.command      <= CMD_WRITE_SAMPLE;
    item_bus.index        <= '0;
    item_bus.sample_value <= '0;
    item_bus.start_phase  <= '0;
    item_bus.phase_step   <= '0;
    item_bus.voice_gain   <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= CFG_ACTIVE_VOICES;
    cfg_bus.data          <= '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unused register index, then zero voices in plain mode
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    set_config(0, 1'b0);

    // Zero active voices gives a silent frame; unused command does nothing
    send_tick();
    send_item(CMD_SPARE, '1, '1, '1, '1, '1);

    // Fill the whole store, extremes at the ends of each 64-word block
    for (int addr = 0; addr < DEPTH; addr++) begin
      value = SAMPLE_W'($urandom);
      if (addr % 64 == 0) value = 16'h8000;
      if (addr % 64 == 63) value = 16'h7fff;
      send_sample(INDEX_W'(addr), value);
    end
    for (int v = 0; v < VOICES; v++) begin
      send_voice(INDEX_W'(v), $urandom, $urandom_range(0, 32'h0002_0000), GAIN_W'($urandom));
    end

    // Extreme voices: phase wrap, full gain both ways, store wrap, zero gain
    send_voice(INDEX_W'(0), 32'hffff_ffff, 32'hffff_ffff, 16'h8000);
    send_voice(INDEX_W'(VOICES - 1), 32'h01ff_8000, 32'h0000_0000, 16'h7fff);
    send_voice(INDEX_W'(1), 32'h0000_0000, 32'h0001_0000, 16'h0000);
    // Voice numbers beyond the table are ignored
    send_voice(INDEX_W'(VOICES), 32'h0, 32'h0, 16'h7fff);
    send_voice(9'h1ff, '1, '1, 16'h8000);
    send_sample(INDEX_W'(0), 16'h8000);
    send_sample(INDEX_W'(1), 16'h7fff);
    send_sample(INDEX_W'(DEPTH - 2), 16'h8000);
    send_sample(INDEX_W'(DEPTH - 1), 16'h7fff);
    send_item(CMD_SPARE, '0, '0, '0, '0, '0);

    wait_idle();
    set_config(VOICES, 1'b1);
    send_tick();
    send_tick();
    wait_idle();
    // More active voices than slots counts as all slots
    set_config(31, 1'b0);
    send_tick();
    wait_idle();
    set_config(1, 1'b1);
    send_tick();

    // Random phases over a spread of settings
    phase_voices = '{VOICES, 31, 0, 12, 1, 0, 0, VOICES, VOICES};
    phase_interp = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_voices[5] = $urandom_range(2, VOICES - 1);
    phase_voices[6] = $urandom_range(2, 31);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == NUM_PHASES - 1) gaps_on = 1'b0;
      set_config(phase_voices[p], phase_interp[p]);
      if (p == 1) begin
        // Long output stall while ticks keep coming
        hold_req = 1'b1;
        repeat (40) send_tick();
        repeat (PHASE_ITEMS - 40) send_random_item();
      end else begin
        repeat (PHASE_ITEMS) send_random_item();
      end
    end

    wait_idle();
    if (sb.expected_frames.size() != 0) begin
      sb.errors += sb.expected_frames.size();
      $display("%0t: %0d frames never arrived, expected %0d, actual none", $time,
               sb.expected_frames.size(), sb.expected_frames[0]);
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
